### rtl/hdr_exposure_merge_macros.svh
// assertion macros shared by the merge block rtl
`ifndef HDR_EXPOSURE_MERGE_MACROS_SVH
`define HDR_EXPOSURE_MERGE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define HEM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hem_pkg.sv
// types, constants and the gaussian table function of the exposure merge
package hem_pkg;

  localparam int MAX_EXPOSURES         = 4;
  localparam int GAUSS_TABLE_BITS_DEF  = 10;
  localparam int SAMPLE_W              = 16;
  localparam int WEIGHT_W              = 16;
  localparam int INV_W                 = 32;
  localparam int PROD_W                = WEIGHT_W + INV_W;
  localparam int SUM_W                 = 52;
  localparam int WT_W                  = 19;
  localparam int DEN_W                 = WT_W + 1;
  localparam int RAD_W                 = 32;
  localparam int NUM_CH                = 3;
  localparam int CH_W                  = 2;
  localparam int EXP_IDX_W             = 2;
  localparam int NUM_INV               = 4;
  localparam int CFG_IDX_W             = 3;
  localparam int CFG_DATA_W            = 32;
  localparam logic [INV_W-1:0]    INV_RESET    = 32'h0001_0000;
  localparam logic [WEIGHT_W-1:0] PHOTON_FLOOR = 16'd66;

  typedef enum logic [1:0] {
    WM_UNIFORM = 2'd0,
    WM_TENT    = 2'd1,
    WM_GAUSS   = 2'd2,
    WM_PHOTON  = 2'd3
  } weight_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_MODE = 3'd0,
    CFG_SIXTEEN_BIT = 3'd1,
    CFG_INV_EXP_0   = 3'd2,
    CFG_INV_EXP_1   = 3'd3,
    CFG_INV_EXP_2   = 3'd4,
    CFG_INV_EXP_3   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WEIGHT,
    ST_MUL_WZ,
    ST_MUL_INV,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample_red;
    logic [SAMPLE_W-1:0]  sample_green;
    logic [SAMPLE_W-1:0]  sample_blue;
    logic [EXP_IDX_W-1:0] exposure_index;
    logic                 last_exposure;
  } in_item_t;

  typedef struct packed {
    logic [RAD_W-1:0] radiance_red;
    logic [RAD_W-1:0] radiance_green;
    logic [RAD_W-1:0] radiance_blue;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // one gaussian table entry, evaluated at elaboration only
  // exp(-x) as the eighth power, by three squarings, of a series of exp(-x/8) through its tenth-order term, Q30
  function automatic logic [WEIGHT_W-1:0] gauss_entry(int unsigned idx, int unsigned bits);
    logic [63:0] half, c, ad, x16, u, term, pos, neg, r, w;
    half = 64'd1 << bits;
    c    = 64'd2 * 64'(idx) + 64'd1;
    ad   = (c >= half) ? (c - half) : (half - c);
    x16  = ((64'd25 * ad * ad) << 16) >> (2 * bits + 3);
    u    = x16 << 11;
    term = 64'd1 << 30;
    pos  = 64'd1 << 30;
    neg  = 64'd0;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * u) >> 30) / 64'(n);
      if ((n % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    r = (pos > neg) ? (pos - neg) : 64'd0;
    if (r > (64'd1 << 30)) r = 64'd1 << 30;
    for (int k = 0; k < 3; k++) r = (r * r) >> 30;
    w = (r * 64'd65535 + (64'd1 << 29)) >> 30;
    return (w > 64'd65535) ? 16'hFFFF : w[WEIGHT_W-1:0];
  endfunction

endpackage

### rtl/hem_stream_if.sv
// valid/ready stream channel carrying one payload item
interface hem_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/hem_weight.sv
// weight curve unit: gaussian rom and per-mode weight on registered inputs
module hem_weight #(
  parameter int GAUSS_TABLE_BITS = hem_pkg::GAUSS_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic [hem_pkg::SAMPLE_W-1:0]  z,
  input  hem_pkg::weight_mode_t         mode,
  output logic [hem_pkg::SAMPLE_W-1:0]  z_q,
  output logic [hem_pkg::WEIGHT_W-1:0]  w_q
);
  import hem_pkg::*;

  localparam int RomDepth = 1 << GAUSS_TABLE_BITS;

  logic [WEIGHT_W-1:0] gauss_rom [RomDepth];
  logic [WEIGHT_W-1:0] rom_q_r;
  logic [SAMPLE_W-1:0] z_r;
  weight_mode_t        mode_r;

  for (genvar i = 0; i < RomDepth; i++) begin : g_rom
    assign gauss_rom[i] = gauss_entry(i, GAUSS_TABLE_BITS);
  end

  // table indexed by the top bits of the sample fraction
  always_ff @(posedge clk) begin
    rom_q_r <= gauss_rom[z[SAMPLE_W-1:SAMPLE_W-GAUSS_TABLE_BITS]];
    z_r     <= z;
    mode_r  <= mode;
  end

  always_comb begin
    case (mode_r)
      WM_UNIFORM: w_q = '1;
      WM_TENT:    w_q = z_r[SAMPLE_W-1] ? ~z_r : z_r;
      WM_GAUSS:   w_q = rom_q_r;
      WM_PHOTON:  w_q = (z_r < PHOTON_FLOOR) ? PHOTON_FLOOR : z_r;
      default:    w_q = '1;
    endcase
  end

  assign z_q = z_r;

endmodule

### rtl/hem_div.sv
// restoring divider, one quotient bit per cycle
`include "hdr_exposure_merge_macros.svh"
module hem_div #(
  parameter int NUM_W = hem_pkg::SUM_W,
  parameter int DEN_W = hem_pkg::DEN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic [NUM_W-1:0]    quo,
  output hem_pkg::div_status_t status
);
  import hem_pkg::*;

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CntW-1:0]  cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // numerator bits shift out the top while quotient bits shift in below
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo         = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

  `HEM_ASSERT_IMP(a_no_restart, clk, rst_n, start, !busy_r, "divider started while busy")
  `HEM_ASSERT_IMP(a_rem_below_den, clk, rst_n, busy_r, rem_r < den_r, "remainder not below divisor")
  `HEM_ASSERT_NXT(a_done_at_end, clk, rst_n, busy_r && cnt_r == CntW'(1) && !start, done_r, "divider missed done")

endmodule

### rtl/hdr_exposure_merge.sv
// top level of the multi-exposure radiance merge
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       three samples, exposure index, last flag
//   out_ch   out  valid/ready       three Q16.16 radiances
//   cfg_*    in   write enable only register index, 32-bit data
//
// an item is accepted, then weight, w*z, *inv and accumulate run for each of three
// channels in turn on one shared 16x32 multiplier
// an item marked last then needs, per channel, a load, 52 divide steps and a done
// on one restoring divider, then an emit
// the result waits in an output register, so the next item is taken while it is pending
// a stalled output holds the block in its emit state only if a second result is ready
// synchronous active-low reset clears control, accumulators and config registers; no clearing pass
`include "hdr_exposure_merge_macros.svh"
module hdr_exposure_merge #(
  parameter int GAUSS_TABLE_BITS = hem_pkg::GAUSS_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  hem_stream_if.sink                      in_ch,
  hem_stream_if.source                    out_ch,
  input  logic                            cfg_wr_en,
  input  logic [hem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hem_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import hem_pkg::*;

  localparam logic [CH_W-1:0] LastCh = CH_W'(NUM_CH - 1);

  weight_mode_t         weight_mode_r;
  logic                 sixteen_r;
  logic [INV_W-1:0]     inv_r [NUM_INV];
  logic [SUM_W-1:0]     sum_r [NUM_CH];
  logic [WT_W-1:0]      wt_r [NUM_CH];
  logic [SAMPLE_W-1:0]  samp_r [NUM_CH];
  logic [EXP_IDX_W-1:0] idx_r;
  logic                 last_r;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  state_t               state_r, state_nxt;
  logic [PROD_W-1:0]    mul_r;
  logic [WEIGHT_W-1:0]  w_r;
  logic [RAD_W-1:0]     res_r [NUM_CH];
  out_item_t            out_data_r;
  logic                 out_valid_r;

  logic [SAMPLE_W-1:0]  samp_cur, z_cur, z_q;
  logic [WEIGHT_W-1:0]  w_q;
  logic [WEIGHT_W-1:0]  mul_a;
  logic [INV_W-1:0]     mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic                 in_acc, div_start, emit, idx_ok;
  logic [SUM_W:0]       sum_add;
  logic [WT_W:0]        wt_add;
  logic [DEN_W-1:0]     div_den;
  logic [SUM_W-1:0]     div_quo;
  logic [RAD_W-1:0]     quo_sat;
  div_status_t          div_status;

  // 8-bit samples scale by 257, which is the byte repeated
  assign samp_cur = samp_r[ch_r];
  assign z_cur    = sixteen_r ? samp_cur : {samp_cur[7:0], samp_cur[7:0]};
  assign idx_ok   = int'(idx_r) < MAX_EXPOSURES;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sum_add  = {1'b0, sum_r[ch_r]} + (SUM_W + 1)'(mul_r);
  assign wt_add   = {1'b0, wt_r[ch_r]} + (WT_W + 1)'(w_r);
  assign div_den  = {1'b0, wt_r[ch_r]} + DEN_W'(1);
  assign quo_sat  = (|div_quo[SUM_W-1:RAD_W]) ? '1 : div_quo[RAD_W-1:0];

  hem_weight #(
    .GAUSS_TABLE_BITS (GAUSS_TABLE_BITS)
  ) u_weight (
    .clk  (clk),
    .z    (z_cur),
    .mode (weight_mode_r),
    .z_q  (z_q),
    .w_q  (w_q)
  );

  hem_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (sum_r[ch_r]),
    .den    (div_den),
    .quo    (div_quo),
    .status (div_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    div_start = 1'b0;
    emit      = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_WEIGHT;
          ch_nxt    = '0;
        end
      end
      ST_WEIGHT: state_nxt = ST_MUL_WZ;
      ST_MUL_WZ: begin
        mul_a     = w_q;
        mul_b     = INV_W'(z_q);
        state_nxt = ST_MUL_INV;
      end
      ST_MUL_INV: begin
        mul_a     = mul_r[2*WEIGHT_W-1:WEIGHT_W];
        mul_b     = inv_r[idx_r];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (ch_r == LastCh) begin
          ch_nxt    = '0;
          state_nxt = last_r ? ST_DIV_LOAD : ST_IDLE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_WEIGHT;
        end
      end
      ST_DIV_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (div_status.done) begin
          if (ch_r == LastCh) begin
            ch_nxt    = '0;
            state_nxt = ST_EMIT;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = ST_DIV_LOAD;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_mode_r <= WM_UNIFORM;
      sixteen_r     <= 1'b0;
      for (int i = 0; i < NUM_INV; i++) inv_r[i] <= INV_RESET;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= '0;
        wt_r[c]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_WEIGHT_MODE: weight_mode_r <= weight_mode_t'(cfg_wr_data[1:0]);
          CFG_SIXTEEN_BIT: sixteen_r <= cfg_wr_data[0];
          CFG_INV_EXP_0:   inv_r[0] <= cfg_wr_data;
          CFG_INV_EXP_1:   inv_r[1] <= cfg_wr_data;
          CFG_INV_EXP_2:   inv_r[2] <= cfg_wr_data;
          CFG_INV_EXP_3:   inv_r[3] <= cfg_wr_data;
          default: ;
        endcase
      end
      if (state_r == ST_ACC && idx_ok) begin
        sum_r[ch_r] <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        wt_r[ch_r]  <= wt_add[WT_W] ? '1 : wt_add[WT_W-1:0];
      end
      // the divider has latched this channel, so it starts over
      if (div_start) begin
        sum_r[ch_r] <= '0;
        wt_r[ch_r]  <= '0;
      end
    end
  end

  // item payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r[0] <= in_ch.data.sample_red;
      samp_r[1] <= in_ch.data.sample_green;
      samp_r[2] <= in_ch.data.sample_blue;
      idx_r     <= in_ch.data.exposure_index;
      last_r    <= in_ch.data.last_exposure;
    end
    if (state_r == ST_MUL_WZ) w_r <= w_q;
    if (state_r == ST_MUL_WZ || state_r == ST_MUL_INV) mul_r <= mul_p;
    if (state_r == ST_DIV_RUN && div_status.done) res_r[ch_r] <= quo_sat;
    if (emit) begin
      out_data_r.radiance_red   <= res_r[0];
      out_data_r.radiance_green <= res_r[1];
      out_data_r.radiance_blue  <= res_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `HEM_ASSERT_NXT(a_accept_busy, clk, rst_n, in_acc, state_r == ST_WEIGHT && !in_ch.ready, "accepted item did not start work")
  `HEM_ASSERT_IMP(a_done_in_run, clk, rst_n, div_status.done, state_r == ST_DIV_RUN, "divide finished outside run state")
  `HEM_ASSERT_NXT(a_emit_valid, clk, rst_n, emit, out_valid_r, "emitted item not presented")
  `HEM_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, state_r == ST_IDLE, !div_status.busy, "divider busy while idle")

endmodule

### verif/testbench.sv
// self-checking testbench for the exposure merge block: random bursts, output stalls, config sweeps
module testbench;
  import hem_pkg::*;

  localparam int          GT_BITS   = GAUSS_TABLE_BITS_DEF;
  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] SUM_CAP   = (64'd1 << SUM_W) - 64'd1;
  localparam logic [19:0] WT_CAP    = (20'd1 << WT_W) - 20'd1;
  localparam int          PHASES    = 9;
  localparam int          PER_PHASE = 90;
  localparam int          SETTLE    = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  hem_stream_if #(.payload_t(in_item_t))  in_if ();
  hem_stream_if #(.payload_t(out_item_t)) out_if ();

  hdr_exposure_merge u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor copy of registers and accumulators
  weight_mode_t    cur_mode;
  logic            sixteen_mode;
  logic [31:0]     inv_time [NUM_INV];
  logic [SUM_W-1:0] sum_acc [NUM_CH];
  logic [WT_W-1:0]  wt_acc [NUM_CH];
  logic [15:0]     gauss_rom [1 << GT_BITS];

  in_item_t  exposure_queue [$];
  out_item_t radiance_due [$];
  out_item_t want;

  int mismatches;
  int queued_count;
  int items_taken;
  int pixels_checked;
  int gap_left;
  int burst_left;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // gaussian weight: exp(-x) in Q30 via a series of exp(-x/8) to its tenth-order term, then three squarings
  function automatic logic [15:0] gauss_level(int unsigned slot);
    logic [63:0] mid, twice, span, x_q16, arg, term, plus, minus, e, rounded;
    mid   = 64'd1 << GT_BITS;
    twice = 64'd2 * 64'(slot) + 64'd1;
    span  = (twice >= mid) ? (twice - mid) : (mid - twice);
    x_q16 = ((64'd25 * span * span) << 16) >> (2 * GT_BITS + 3);
    arg   = x_q16 << 11;
    term  = Q30_ONE;
    plus  = Q30_ONE;
    minus = 64'd0;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * arg) >> 30) / 64'(n);
      if (n % 2 == 1) minus = minus + term;
      else plus = plus + term;
    end
    e = (plus > minus) ? (plus - minus) : 64'd0;
    if (e > Q30_ONE) e = Q30_ONE;
    for (int k = 0; k < 3; k++) e = (e * e) >> 30;
    rounded = (e * 64'd65535 + (64'd1 << 29)) >> 30;
    return (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
  endfunction

  function automatic logic [15:0] weight_for(logic [15:0] z);
    case (cur_mode)
      WM_TENT:   return z[15] ? (16'hFFFF - z) : z;
      WM_GAUSS:  return gauss_rom[z >> (16 - GT_BITS)];
      WM_PHOTON: return (z < PHOTON_FLOOR) ? PHOTON_FLOOR : z;
      default:   return 16'hFFFF;
    endcase
  endfunction

  // accumulate one exposure; on the last one queue the expected radiance
  task automatic absorb_exposure(in_item_t it);
    logic [15:0] raw [NUM_CH];
    logic [31:0] rad [NUM_CH];
    logic [15:0] z, w;
    logic [63:0] term, grown, q;
    logic [19:0] wt_grown;
    out_item_t   res;
    raw[0] = it.sample_red;
    raw[1] = it.sample_green;
    raw[2] = it.sample_blue;
    if (int'(it.exposure_index) < MAX_EXPOSURES) begin
      for (int c = 0; c < NUM_CH; c++) begin
        z = sixteen_mode ? raw[c] : 16'(raw[c][7:0] * 16'd257);
        w = weight_for(z);
        term = ((64'(w) * 64'(z)) >> 16) * 64'(inv_time[it.exposure_index]);
        grown = 64'(sum_acc[c]) + term;
        sum_acc[c] = (grown > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : grown[SUM_W-1:0];
        wt_grown = 20'(wt_acc[c]) + 20'(w);
        wt_acc[c] = (wt_grown > WT_CAP) ? WT_CAP[WT_W-1:0] : wt_grown[WT_W-1:0];
      end
    end
    if (it.last_exposure) begin
      for (int c = 0; c < NUM_CH; c++) begin
        q = 64'(sum_acc[c]) / (64'(wt_acc[c]) + 64'd1);
        rad[c] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        sum_acc[c] = '0;
        wt_acc[c] = '0;
      end
      res.radiance_red   = rad[0];
      res.radiance_green = rad[1];
      res.radiance_blue  = rad[2];
      radiance_due.push_back(res);
    end
  endtask

  task automatic flag_mismatch(string what, logic [31:0] exp_val, logic [31:0] got_val);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at %0t: %s expected %h got %h", mismatches, $realtime, what,
               exp_val, got_val);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    case (idx) inside
      CFG_WEIGHT_MODE: cur_mode = weight_mode_t'(data[1:0]);
      CFG_SIXTEEN_BIT: sixteen_mode = data[0];
      [CFG_INV_EXP_0:CFG_INV_EXP_3]:
        inv_time[EXP_IDX_W'(idx - CFG_INV_EXP_0)] = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(weight_mode_t mode, logic wide, logic [31:0] inv_set [NUM_INV]);
    // upper bits of the narrow registers carry junk that must be masked off
    write_reg(CFG_WEIGHT_MODE, {30'($urandom), mode});
    write_reg(CFG_SIXTEEN_BIT, {31'($urandom), wide});
    for (int i = 0; i < NUM_INV; i++)
      write_reg(CFG_IDX_W'(int'(CFG_INV_EXP_0) + i), inv_set[i]);
    // indexes past the register list are ignored
    for (int k = int'(CFG_INV_EXP_3) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), $urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_exposure(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                logic [EXP_IDX_W-1:0] idx, logic last);
    in_item_t it;
    it.sample_red     = r;
    it.sample_green   = g;
    it.sample_blue    = b;
    it.exposure_index = idx;
    it.last_exposure  = last;
    exposure_queue.push_back(it);
    queued_count++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'(32767 + $urandom_range(0, 2));
      4:       return 16'(64 + $urandom_range(0, 4));
      5:       return 16'(8'($urandom));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_inverse();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return INV_RESET;
      3:       return $urandom;
      default: return $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  // mostly short pixels; now and then a long one that can drive the accumulators into saturation
  task automatic queue_random_pixel();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
    for (int i = 0; i < len; i++)
      queue_exposure(pick_sample(), pick_sample(), pick_sample(),
                     EXP_IDX_W'($urandom_range(0, NUM_INV - 1)), i == len - 1);
  endtask

  task automatic settle();
    while (exposure_queue.size() != 0 || in_if.valid || radiance_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        absorb_exposure(in_if.data);
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (exposure_queue.size() > 0) begin
          in_if.data  <= exposure_queue.pop_front();
          in_if.valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: segments of steady ready, short toggling and long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          out_if.ready <= 1'b1;
          hold_left = $urandom_range(1, 60);
        end
        4, 5, 6: begin
          out_if.ready <= ~out_if.ready;
          hold_left = $urandom_range(0, 3);
        end
        default: begin
          out_if.ready <= 1'b0;
          hold_left = $urandom_range(5, 40);
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (radiance_due.size() == 0) begin
        flag_mismatch("result with no pixel pending, red", 32'd0, out_if.data.radiance_red);
      end else begin
        want = radiance_due.pop_front();
        pixels_checked++;
        if (out_if.data.radiance_red !== want.radiance_red)
          flag_mismatch("radiance_red", want.radiance_red, out_if.data.radiance_red);
        if (out_if.data.radiance_green !== want.radiance_green)
          flag_mismatch("radiance_green", want.radiance_green, out_if.data.radiance_green);
        if (out_if.data.radiance_blue !== want.radiance_blue)
          flag_mismatch("radiance_blue", want.radiance_blue, out_if.data.radiance_blue);
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", radiance_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    weight_mode_t mode;
    logic         wide;
    logic [31:0]  inv_set [NUM_INV];
    int           phase_start;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wr_data  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    queued_count = 0;
    items_taken = 0;
    pixels_checked = 0;
    gap_left = 0;
    burst_left = 1;
    hold_left = 0;
    cur_mode = WM_UNIFORM;
    sixteen_mode = 1'b0;
    for (int i = 0; i < NUM_INV; i++) inv_time[i] = INV_RESET;
    for (int c = 0; c < NUM_CH; c++) begin
      sum_acc[c] = '0;
      wt_acc[c] = '0;
    end
    for (int i = 0; i < (1 << GT_BITS); i++) gauss_rom[i] = gauss_level(i);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      // phase 0 runs on the reset register values
      if (phase > 0) begin
        settle();
        for (int i = 0; i < NUM_INV; i++) inv_set[i] = pick_inverse();
        case (phase)
          1: begin
            mode = WM_TENT;
            wide = 1'b1;
            inv_set = '{32'd0, 32'd1, 32'hFFFF_FFFF, INV_RESET};
          end
          2: begin mode = WM_PHOTON; wide = 1'b1; end
          3: begin mode = WM_GAUSS; wide = 1'b0; end
          4: begin mode = WM_GAUSS; wide = 1'b1; end
          5: begin
            mode = WM_UNIFORM;
            wide = 1'b1;
            inv_set = '{default: 32'hFFFF_FFFF};
          end
          6: begin mode = WM_PHOTON; wide = 1'b0; end
          7: begin mode = WM_TENT; wide = 1'b0; end
          default: begin
            mode = WM_UNIFORM;
            wide = 1'b0;
            inv_set = '{default: 32'd0};
          end
        endcase
        apply_settings(mode, wide, inv_set);
      end

      case (phase)
        0: begin
          // all-zero pixel, then a pixel over every exposure with junk in the high bytes
          queue_exposure(16'h0000, 16'h0000, 16'h0000, 2'd0, 1'b1);
          queue_exposure(16'hFFFF, 16'h00FF, 16'hFF00, 2'd0, 1'b0);
          queue_exposure(16'h0080, 16'h0001, 16'hFFFE, 2'd1, 1'b0);
          queue_exposure(16'hAAAA, 16'h5555, 16'h00FF, 2'd2, 1'b0);
          queue_exposure(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1);
        end
        1: begin
          // tent peak and both slopes around the midpoint
          queue_exposure(16'd32767, 16'd32768, 16'hFFFF, 2'd0, 1'b0);
          queue_exposure(16'd0, 16'd1, 16'd32766, 2'd1, 1'b0);
          queue_exposure(16'd32769, 16'hFFFE, 16'd16384, 2'd2, 1'b0);
          queue_exposure(16'd49152, 16'd32767, 16'd8, 2'd3, 1'b1);
        end
        2: begin
          // photon floor below, at and above the clamp
          queue_exposure(16'd0, 16'd65, 16'd66, 2'd0, 1'b1);
          queue_exposure(16'd67, 16'hFFFF, 16'd1, 2'd3, 1'b1);
        end
        3: begin
          queue_exposure(16'h0000, 16'h0080, 16'h00FF, 2'd0, 1'b1);
          queue_exposure(16'h007F, 16'h0040, 16'h00C0, 2'd1, 1'b1);
        end
        5: begin
          // long bright pixel: the weight total hits its cap
          for (int i = 0; i < 12; i++)
            queue_exposure(16'hFFFF, 16'hFFFF, 16'hFFFF, EXP_IDX_W'(i % NUM_INV), i == 11);
        end
        default: ;
      endcase

      phase_start = queued_count;
      while (queued_count < phase_start + PER_PHASE) queue_random_pixel();
    end

    settle();
    $display("merged %0d exposures into %0d checked pixels across %0d register settings",
             items_taken, pixels_checked, PHASES);
    $display("weight curves: uniform, tent, gaussian, photon; 8- and 16-bit samples");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
